### hw/rtl/assert_macros.svh
// assertion macros for the rtl modules, included by mfs_fifo
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mfs_pkg.sv
// types, constants and codes of the multilevel feedback scheduler
package mfs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int LVL_W       = 2;
  localparam int QNT_W       = 4;
  localparam int OP_W        = 3;
  localparam int NUM_Q       = 4;
  localparam int NUM_LVL     = 3;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;
  localparam int OUT_PAD_W   = OUT_DATA_W - ID_W - LVL_W - QNT_W;

  localparam logic [QNT_W-1:0] DELTA1 = 4'd1;
  localparam logic [QNT_W-1:0] DELTA2 = 4'd2;
  localparam logic [QNT_W-1:0] DELTA3 = 4'd4;

  // levels, 0 highest
  localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOW = 2'd2;

  // queue slots
  localparam logic [1:0] Q_L1   = 2'd0;
  localparam logic [1:0] Q_L2   = 2'd1;
  localparam logic [1:0] Q_L3   = 2'd2;
  localparam logic [1:0] Q_WAIT = 2'd3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_QL1 = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_QL2 = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_QL3 = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ADMIT    = 3'd0,
    OP_DISPATCH = 3'd1,
    OP_END_TERM = 3'd2,
    OP_END_CPU  = 3'd3,
    OP_END_IO   = 3'd4,
    OP_IO_DONE  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_IDLE = 2'd1,
    ST_FULL = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wdata;
  } fifo_ctrl_t;

  typedef struct packed {
    logic   full;
    logic   empty;
    entry_t head;
  } fifo_stat_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] level;
    logic [QNT_W-1:0] quantum;
    status_t          status;
  } result_t;

  typedef logic [NUM_LVL-1:0][QNT_W-1:0] quanta_t;

endpackage

### hw/rtl/multilevel_feedback_scheduler.sv
// top level of the three-level feedback-queue scheduler
//
//  channel  direction  signals                        content
//  in_      slave      in_tvalid/tready/tdata/tuser   task id, operation code
//  out_     master     out_tvalid/tready/tdata/tuser  id, level, quantum, status
//  cfg_     write      cfg_wr_en/addr/wdata           quantum per level
//
// one result per transaction, one transaction per cycle sustained while out_tready stays high
// path: input register, then decode and queue update into the result register
// the active task and queue pointers are updated in the same cycle as the result register
// reset is synchronous and empties all queues; queue storage is not cleared
// a stalled result holds the result register and one more transaction in the input register

module multilevel_feedback_scheduler
  import mfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // task_id[15:0]
  input  logic [OP_W-1:0]       in_tuser,   // operation[2:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // task_id_out[15:0], level_out[17:16],
                                            // quantum_out[21:18], zero[23:22]
  output logic [1:0]            out_tuser,  // status[1:0]
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [QNT_W-1:0]      cfg_wdata
);

  logic                   vld_r, vld_nxt;
  logic [OP_W-1:0]        op_r;
  logic [ID_W-1:0]        id_r;
  logic                   out_vld_r, out_vld_nxt;
  result_t                res_r;
  result_t                res;
  quanta_t                quanta_r;
  logic                   proceed;
  logic                   fire;
  logic                   in_acc;
  fifo_ctrl_t [NUM_Q-1:0] ctrl;
  fifo_stat_t [NUM_Q-1:0] stat;

  assign proceed   = !out_vld_r || out_tready;
  assign fire      = vld_r && proceed;
  assign in_tready = !vld_r || proceed;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (in_acc) begin
      vld_nxt = 1'b1;
    end else if (proceed) begin
      vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_tuser;
      id_r <= in_tdata[ID_W-1:0];
    end
    if (fire) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quanta_r[0] <= DELTA1;
      quanta_r[1] <= DELTA2;
      quanta_r[2] <= DELTA3;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_QL1: quanta_r[0] <= cfg_wdata;
        CFG_QL2: quanta_r[1] <= cfg_wdata;
        CFG_QL3: quanta_r[2] <= cfg_wdata;
        default: quanta_r    <= quanta_r;
      endcase
    end
  end

  mfs_sched u_sched (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .op     (op_r),
    .id     (id_r),
    .quanta (quanta_r),
    .stat   (stat),
    .ctrl   (ctrl),
    .res    (res)
  );

  for (genvar q = 0; q < NUM_Q; q++) begin : g_queue
    mfs_fifo u_fifo (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl[q]),
      .stat  (stat[q])
    );
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {OUT_PAD_W'(0), res_r.quantum, res_r.level, res_r.id};
  assign out_tuser  = res_r.status;

endmodule

### hw/rtl/mfs_fifo.sv
// one task queue: register storage with head pointer and fill count
`include "assert_macros.svh"

module mfs_fifo
  import mfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_ctrl_t ctrl,
  output fifo_stat_t stat
);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   tail;

  // depth is a power of two, so pointers wrap by overflow
  assign tail = head_r + cnt_r[PTR_W-1:0];

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (ctrl.pop) begin
      head_nxt = head_r + PTR_W'(1);
    end
    case ({ctrl.push, ctrl.pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem_r[tail] <= ctrl.wdata;
    end
  end

  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.head  = mem_r[head_r];

  `ASSERT_NOW(a_no_push_full, ctrl.push, !stat.full, "push into full queue")
  `ASSERT_NOW(a_no_pop_empty, ctrl.pop, !stat.empty, "pop from empty queue")
  `ASSERT_NEXT(a_cnt_inc, ctrl.push && !ctrl.pop, cnt_r == $past(cnt_r) + CNT_W'(1), "no grow")

endmodule

### hw/rtl/mfs_sched.sv
// operation decode, queue control and active task registers
module mfs_sched
  import mfs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  logic [OP_W-1:0]         op,
  input  logic [ID_W-1:0]         id,
  input  quanta_t                 quanta,
  input  fifo_stat_t [NUM_Q-1:0]  stat,
  output fifo_ctrl_t [NUM_Q-1:0]  ctrl,
  output result_t                 res
);

  logic [ID_W-1:0]        act_id_r, act_id_nxt;
  logic [LVL_W-1:0]       act_lvl_r, act_lvl_nxt;
  logic                   act_vld_r, act_vld_nxt;
  fifo_ctrl_t [NUM_Q-1:0] req;
  logic [LVL_W-1:0]       pick;
  logic                   any_ready;
  logic [QNT_W-1:0]       pick_qnt;
  logic [LVL_W-1:0]       tgt;
  entry_t                 wait_head;

  // highest non-empty ready level
  always_comb begin
    any_ready = 1'b1;
    if (!stat[Q_L1].empty) begin
      pick = LVL_TOP;
    end else if (!stat[Q_L2].empty) begin
      pick = LVL_MID;
    end else if (!stat[Q_L3].empty) begin
      pick = LVL_LOW;
    end else begin
      pick      = LVL_TOP;
      any_ready = 1'b0;
    end
  end

  always_comb begin
    case (pick)
      LVL_TOP: pick_qnt = quanta[0];
      LVL_MID: pick_qnt = quanta[1];
      default: pick_qnt = quanta[2];
    endcase
  end

  assign wait_head = stat[Q_WAIT].head;

  always_comb begin
    req         = '0;
    res         = '0;
    act_id_nxt  = act_id_r;
    act_lvl_nxt = act_lvl_r;
    act_vld_nxt = act_vld_r;
    tgt         = LVL_TOP;
    case (op_t'(op))
      OP_ADMIT: begin
        if (stat[Q_L1].full) begin
          res.status = ST_FULL;
        end else begin
          req[Q_L1].push  = 1'b1;
          req[Q_L1].wdata = '{level: LVL_TOP, id: id};
          res.id          = id;
        end
      end
      OP_DISPATCH: begin
        if (!any_ready) begin
          res.status = ST_IDLE;
        end else begin
          req[pick].pop = 1'b1;
          act_id_nxt    = stat[pick].head.id;
          act_lvl_nxt   = pick;
          act_vld_nxt   = 1'b1;
          res.id        = stat[pick].head.id;
          res.level     = pick;
          res.quantum   = pick_qnt;
        end
      end
      OP_END_TERM: begin
        if (!act_vld_r) begin
          res.status = ST_NONE;
        end else begin
          act_vld_nxt = 1'b0;
          res.id      = act_id_r;
          res.level   = act_lvl_r;
        end
      end
      OP_END_CPU: begin
        tgt = (act_lvl_r >= LVL_MID) ? LVL_LOW : LVL_MID;
        if (!act_vld_r) begin
          res.status = ST_NONE;
        end else if (stat[tgt].full) begin
          res.status = ST_FULL;
        end else begin
          req[tgt].push  = 1'b1;
          req[tgt].wdata = '{level: tgt, id: act_id_r};
          act_vld_nxt    = 1'b0;
          res.id         = act_id_r;
          res.level      = tgt;
        end
      end
      OP_END_IO: begin
        tgt = (act_lvl_r > LVL_LOW) ? LVL_LOW : act_lvl_r;
        if (!act_vld_r) begin
          res.status = ST_NONE;
        end else if (stat[Q_WAIT].full) begin
          res.status = ST_FULL;
        end else begin
          req[Q_WAIT].push  = 1'b1;
          req[Q_WAIT].wdata = '{level: tgt, id: act_id_r};
          act_vld_nxt       = 1'b0;
          res.id            = act_id_r;
          res.level         = tgt;
        end
      end
      OP_IO_DONE: begin
        tgt = (wait_head.level >= LVL_LOW) ? LVL_MID : LVL_TOP;
        if (stat[Q_WAIT].empty) begin
          res.status = ST_NONE;
        end else if (stat[tgt].full) begin
          res.status = ST_FULL;
        end else begin
          req[Q_WAIT].pop = 1'b1;
          req[tgt].push   = 1'b1;
          req[tgt].wdata  = '{level: tgt, id: wait_head.id};
          res.id          = wait_head.id;
          res.level       = tgt;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // queue effects only when the transaction is actually processed
  always_comb begin
    for (int q = 0; q < NUM_Q; q++) begin
      ctrl[q].push  = req[q].push & fire;
      ctrl[q].pop   = req[q].pop & fire;
      ctrl[q].wdata = req[q].wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_id_r  <= '0;
      act_lvl_r <= LVL_TOP;
      act_vld_r <= 1'b0;
    end else if (fire) begin
      act_id_r  <= act_id_nxt;
      act_lvl_r <= act_lvl_nxt;
      act_vld_r <= act_vld_nxt;
    end
  end

endmodule
